FILE: hdl/postfix_stack_evaluator_defines.svh
// Assertion shorthands used by the evaluator RTL.
// Each expects clk and arst_n in scope.
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication.
`define PSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

	localparam int DATA_W = 32;
	localparam int OPND_W = 31;

	typedef enum logic [2:0] {
		MODE_OPERAND = 3'd0,
		MODE_ADD     = 3'd1,
		MODE_SUB     = 3'd2,
		MODE_MUL     = 3'd3,
		MODE_DIV     = 3'd4,
		MODE_REM     = 3'd5,
		MODE_INVALID = 3'd6,
		MODE_END     = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_FEW      = 3'd1,
		STS_DIVZERO  = 3'd2,
		STS_INVALID  = 3'd3,
		STS_LEFTOVER = 3'd4,
		STS_OVERFLOW = 3'd5
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [OPND_W-1:0]  operand;
	} token_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV
	} state_t;

endpackage

FILE: hdl/pse_ram.sv
`timescale 1ns / 1ps

module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/pse_divider.sv
`timescale 1ns / 1ps

// Signed truncating divide, one quotient bit per cycle on magnitudes.
module pse_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pse_pkg::DATA_W-1:0]  dividend,
	input  logic [pse_pkg::DATA_W-1:0]  divisor,
	output logic                        done,
	output logic [pse_pkg::DATA_W-1:0]  quotient,
	output logic [pse_pkg::DATA_W-1:0]  remainder
);

	localparam int W  = pse_pkg::DATA_W;
	localparam int NW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic          qneg_q;
	logic          rneg_q;

	logic [W:0]    shifted;
	logic          ge;
	logic [W:0]    diff;
	logic [W-1:0]  dividend_mag;
	logic [W-1:0]  divisor_mag;

	// Most negative value maps to its own bit pattern, which is the right magnitude.
	assign dividend_mag = dividend[W-1] ? (~dividend + 1'b1) : dividend;
	assign divisor_mag  = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == NW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend_mag;
			dvs_q  <= divisor_mag;
			qneg_q <= dividend[W-1] ^ divisor[W-1];
			rneg_q <= dividend[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = qneg_q ? (~quo_q + 1'b1) : quo_q;
	assign remainder = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule

FILE: hdl/postfix_stack_evaluator.sv
`timescale 1ns / 1ps

// Postfix expression evaluator. Feed decoded tokens on the tok channel; each
// end-of-expression token produces exactly one beat on the res channel with the
// final value (or zero) and a status, and starts a fresh expression. The top of
// the stack sits in a register and the entries below it in a one-port-write,
// registered-read RAM of STACK_DEPTH words, so an operator needs a single RAM
// read. Operand, invalid and end tokens, and any token after an error, are
// handled in the idle state alone; add, sub and mul read the second entry,
// then compute; div and rem read it, then start the bit-serial divider,
// which retires one quotient bit per cycle, and wait for it to finish. The
// block holds one token at a time, so the tok channel stalls while an
// operator is in flight. A finished result waits in an output register while
// further tokens are taken; of those, only an end token stalls on it, and
// only while that register is full and stalled downstream.
`include "postfix_stack_evaluator_defines.svh"

module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	output logic             tok_stall,
	input  pse_pkg::token_t  tok,
	output logic             res_valid,
	input  logic             res_stall,
	output pse_pkg::result_t res
);

	localparam int W  = pse_pkg::DATA_W;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// Control state
	pse_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	pse_pkg::status_t err_q, err_d;
	logic             res_valid_q, res_valid_d;

	// Payload
	logic [W-1:0]     tos_q, tos_d;
	pse_pkg::result_t res_q, res_d;
	pse_pkg::mode_t   op_q, op_d;

	logic             tok_accept;
	logic             ram_we;
	logic [CW-1:0]    count_dec;
	logic [CW-1:0]    count_dec2;
	logic [W-1:0]     lhs;
	logic [2*W-1:0]   prod;
	logic [W-1:0]     alu_res;
	logic             div_start;
	logic             div_done;
	logic [W-1:0]     div_quo;
	logic [W-1:0]     div_rem;
	logic             is_divide;
	pse_pkg::status_t end_status;

	// Stall any token while an operator is in flight, and an end token that would overwrite an untaken result.
	assign tok_stall = (state_q != pse_pkg::ST_IDLE) ||
		((tok.mode == pse_pkg::MODE_END) && res_valid_q && res_stall);
	assign tok_accept = tok_valid && !tok_stall;

	assign count_dec  = count_q - CW'(1);
	assign count_dec2 = count_q - CW'(2);

	// Entries below the top: push spills the old top to slot count-1, an
	// operator reads its left operand from slot count-2.
	pse_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_dec[AW-1:0]),
		.wdata(tos_q),
		.raddr(count_dec2[AW-1:0]),
		.rdata(lhs)
	);

	pse_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lhs),
		.divisor  (tos_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign prod = lhs * tos_q;

	always_comb begin
		case (op_q)
			pse_pkg::MODE_ADD: alu_res = lhs + tos_q;
			pse_pkg::MODE_SUB: alu_res = lhs - tos_q;
			pse_pkg::MODE_MUL: alu_res = prod[W-1:0];
			default:           alu_res = tos_q;
		endcase
	end

	assign is_divide = (op_q == pse_pkg::MODE_DIV) || (op_q == pse_pkg::MODE_REM);

	// Sticky error wins; otherwise exactly one entry must remain.
	always_comb begin
		if (err_q != pse_pkg::STS_OK) begin
			end_status = err_q;
		end else if (count_q == CW'(1)) begin
			end_status = pse_pkg::STS_OK;
		end else begin
			end_status = pse_pkg::STS_LEFTOVER;
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		err_d       = err_q;
		res_valid_d = res_valid_q;
		tos_d       = tos_q;
		res_d       = res_q;
		op_d        = op_q;
		ram_we      = 1'b0;
		div_start   = 1'b0;

		// Drop the result beat once taken.
		if (res_valid_q && !res_stall) begin
			res_valid_d = 1'b0;
		end

		unique case (state_q)
			pse_pkg::ST_IDLE: begin
				if (tok_accept) begin
					if (tok.mode == pse_pkg::MODE_END) begin
						res_d.status = end_status;
						res_d.value  = (end_status == pse_pkg::STS_OK) ? tos_q : '0;
						res_valid_d  = 1'b1;
						count_d      = '0;
						err_d        = pse_pkg::STS_OK;
					end else if (err_q == pse_pkg::STS_OK) begin
						unique case (tok.mode)
							pse_pkg::MODE_OPERAND: begin
								if (count_q == CW'(STACK_DEPTH)) begin
									err_d = pse_pkg::STS_OVERFLOW;
								end else begin
									ram_we  = (count_q != '0);
									tos_d   = {1'b0, tok.operand};
									count_d = count_q + CW'(1);
								end
							end
							pse_pkg::MODE_INVALID: begin
								err_d = pse_pkg::STS_INVALID;
							end
							pse_pkg::MODE_ADD, pse_pkg::MODE_SUB, pse_pkg::MODE_MUL,
							pse_pkg::MODE_DIV, pse_pkg::MODE_REM: begin
								if (count_q < CW'(2)) begin
									err_d = pse_pkg::STS_FEW;
								end else if (((tok.mode == pse_pkg::MODE_DIV) ||
									(tok.mode == pse_pkg::MODE_REM)) && (tos_q == '0)) begin
									err_d = pse_pkg::STS_DIVZERO;
								end else begin
									op_d    = tok.mode;
									state_d = pse_pkg::ST_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			pse_pkg::ST_READ: begin
				// Left operand is on the RAM read port now.
				if (is_divide) begin
					div_start = 1'b1;
					state_d   = pse_pkg::ST_DIV;
				end else begin
					tos_d   = alu_res;
					count_d = count_dec;
					state_d = pse_pkg::ST_IDLE;
				end
			end
			pse_pkg::ST_DIV: begin
				if (div_done) begin
					tos_d   = (op_q == pse_pkg::MODE_DIV) ? div_quo : div_rem;
					count_d = count_dec;
					state_d = pse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pse_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pse_pkg::ST_IDLE;
			count_q     <= '0;
			err_q       <= pse_pkg::STS_OK;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			err_q       <= err_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		res_q <= res_d;
		op_q  <= op_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`PSE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(STACK_DEPTH), "stack count beyond depth")
	`PSE_ASSERT_NOW(a_busy_no_err, state_q != pse_pkg::ST_IDLE, err_q == pse_pkg::STS_OK, "operator in flight with sticky error")
	`PSE_ASSERT_NOW(a_err_zero_value, res_valid_q && (res_q.status != pse_pkg::STS_OK), res_q.value == '0, "error result carries nonzero value")
	`PSE_ASSERT_NOW(a_div_done_state, div_done, state_q == pse_pkg::ST_DIV, "divider finished outside divide wait")
	`PSE_ASSERT_NEXT(a_end_clears, tok_accept && (tok.mode == pse_pkg::MODE_END), (count_q == '0) && (err_q == pse_pkg::STS_OK) && res_valid_q, "end token did not reset expression")

endmodule
